### rtl/core/ccp_pkg.sv
// Package for the character class parser: constants, status codes, cell control type.
// No dependencies; used by every module of the block.
package ccp_pkg;

    localparam int ALPHABET_SIZE = 95;
    // Cells hold indices ch-32 for printable ch below 0x80, so at most 96 are reachable.
    localparam int NUM_CELLS     = (ALPHABET_SIZE < 96) ? ALPHABET_SIZE : 96;
    localparam int IDX_W         = 7;                      // ch-32 for ch < 0x80
    localparam int CNT_W         = $clog2(NUM_CELLS + 1);
    localparam int MASK_LO_W     = 64;
    localparam int MASK_HI_W     = 31;
    localparam int MASK_W        = MASK_LO_W + MASK_HI_W;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 7;
    localparam int OUT_W         = 112;                    // 105 field bits, byte padded

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_HYPHEN    = 8'h2D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HIGH      = 8'h80;
    localparam int         MIN_MEMBERS  = 2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DANGLING    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONPRINT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_START    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_END      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY_RANGE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW     = 3'd6;

    typedef struct packed {
        logic             clear;  // drop all members
        logic             shift;  // rotate one cell toward cell 0
        logic             fill;   // set members lo..hi
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } ccp_cell_ctl_t;

    function automatic logic is_printable(input logic [7:0] c);
        logic [7:0] idx;
        idx = c - CH_SPACE;
        return (c >= CH_SPACE) && (c < CH_HIGH) && (32'(idx) < ALPHABET_SIZE);
    endfunction

endpackage

### rtl/core/ccp_cell.sv
// One membership cell of the character class parser chain.
// Depends on ccp_pkg.
module ccp_cell
    import ccp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ccp_cell_ctl_t       ctl,
    input  logic [IDX_W-1:0]    idx,
    input  logic                nbr_in,
    output logic                member_q
);

    logic member_reg;
    logic member_next;

    always_comb
    begin
        member_next = member_reg;
        if (ctl.clear)
        begin
            member_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            member_next = nbr_in;
        end
        else if (ctl.fill && (idx >= ctl.lo) && (idx <= ctl.hi))
        begin
            member_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= 1'b0;
        end
        else
        begin
            member_reg <= member_next;
        end
    end

    assign member_q = member_reg;

endmodule

### rtl/core/ccp_chain.sv
// Ring of membership cells; rotates toward cell 0 during the count pass.
// Depends on ccp_pkg and ccp_cell.
module ccp_chain
    import ccp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccp_cell_ctl_t        ctl,
    output logic [NUM_CELLS-1:0] members
);

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        ccp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .idx      (IDX_W'(i)),
            .nbr_in   (members[(i + 1) % NUM_CELLS]),
            .member_q (members[i])
        );
    end

endmodule

### rtl/core/character_class_parser.sv
// Top level of the character class parser: parse control, count pass, result register.
// Depends on ccp_pkg, ccp_chain (and through it ccp_cell).
//
// Usage:
//   Slave channel (s_axis_*) takes one specification byte per transfer. Backslash
//   escapes the next byte, "a-z" adds an inclusive range, space or NUL terminates.
//   Master channel (m_axis_*) carries one result per error and per terminator in normal
//   parse mode: status, member count and the 95-bit membership mask.
// Operation:
//   Plain bytes, escapes and ranges update the cells as they are taken; a range sets all its
//   members at once, every cell comparing its own index against the bounds.
//   An error result is visible the cycle after the offending byte.
//   A terminator starts a count pass: the mask rotates once around the ring of
//   NUM_CELLS cells while a counter sums the bit leaving cell 0, then S_DONE
//   loads the result once the result register is free. Through the count pass
//   and S_DONE s_axis_tready is low.
// Reset: all members cleared, normal parse mode, no range start, output empty.
// Stall: the result register holds while m_axis_tready is low. A new byte is still
//   taken as long as the register is free or drains in the same cycle, outside a count pass.
module character_class_parser
    import ccp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // [2:0] status, [9:3] member_count,
                                             // [73:10] mask_low, [104:74] mask_high,
                                             // [111:105] zero
);

    typedef enum logic [6:0] {
        S_NORMAL    = 7'b0000001,
        S_ESC       = 7'b0000010,
        S_RANGE     = 7'b0000100,
        S_RANGE_ESC = 7'b0001000,
        S_FAILED    = 7'b0010000,
        S_COUNT     = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [7:0]             prev_reg, prev_next;       // range start, 0 = none
    logic [CNT_W-1:0]       cnt_reg, cnt_next;         // members seen in count pass
    logic [CNT_W-1:0]       rot_reg, rot_next;         // rotation steps done
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    ccp_cell_ctl_t          cell_ctl;
    logic [NUM_CELLS-1:0]   members;
    logic [MASK_W-1:0]      mask;

    logic                   out_free;
    logic                   accept;
    logic [7:0]             c;
    logic                   term;
    logic                   pr;
    logic [IDX_W-1:0]       c_idx;
    logic [IDX_W-1:0]       prev_idx;

    ccp_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .members (members)
    );

    // Membership vector widened to the result's mask fields
    for (genvar i = 0; i < MASK_W; i++)
    begin : g_mask
        if (i < NUM_CELLS)
        begin : g_on
            assign mask[i] = members[i];
        end
        else
        begin : g_off
            assign mask[i] = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = out_free && (state_reg != S_COUNT) && (state_reg != S_DONE);
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign c        = s_axis_tdata;
    assign term     = (c == CH_NUL) || (c == CH_SPACE);
    assign pr       = is_printable(c);
    assign c_idx    = IDX_W'(c - CH_SPACE);
    assign prev_idx = IDX_W'(prev_reg - CH_SPACE);

    function automatic logic [OUT_W-1:0] err_word(input logic [STATUS_W-1:0] code);
        return {{(OUT_W-STATUS_W){1'b0}}, code};
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        rot_next       = rot_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        cell_ctl       = '0;

        case (state_reg)
            S_NORMAL:
            begin
                if (accept)
                begin
                    if (term)
                    begin
                        prev_next  = 8'd0;
                        cnt_next   = '0;
                        rot_next   = '0;
                        state_next = S_COUNT;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        state_next = S_ESC;
                    end
                    else if (!pr)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_NONPRINT);
                        state_next     = S_FAILED;
                    end
                    else if (c == CH_HYPHEN)
                    begin
                        if (prev_reg == 8'd0)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = err_word(ST_NO_START);
                            state_next     = S_FAILED;
                        end
                        else
                        begin
                            state_next = S_RANGE;
                        end
                    end
                    else
                    begin
                        cell_ctl.fill = 1'b1;
                        cell_ctl.lo   = c_idx;
                        cell_ctl.hi   = c_idx;
                        prev_next     = c;
                    end
                end
            end

            S_ESC:
            begin
                if (accept)
                begin
                    if (c == CH_NUL)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_DANGLING);
                        cell_ctl.clear = 1'b1;
                        prev_next      = 8'd0;
                        state_next     = S_NORMAL;
                    end
                    else if (!pr)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_NONPRINT);
                        state_next     = S_FAILED;
                    end
                    else
                    begin
                        cell_ctl.fill = 1'b1;
                        cell_ctl.lo   = c_idx;
                        cell_ctl.hi   = c_idx;
                        prev_next     = c;
                        state_next    = S_NORMAL;
                    end
                end
            end

            S_RANGE,
            S_RANGE_ESC:
            begin
                if (accept)
                begin
                    if ((state_reg == S_RANGE) && (c == CH_BACKSLASH))
                    begin
                        state_next = S_RANGE_ESC;
                    end
                    else if ((state_reg == S_RANGE) ? term : (c == CH_NUL))
                    begin
                        // terminator where a range end belongs
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_NO_END);
                        cell_ctl.clear = 1'b1;
                        prev_next      = 8'd0;
                        state_next     = S_NORMAL;
                    end
                    else if (!pr)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_NONPRINT);
                        state_next     = S_FAILED;
                    end
                    else if (c < prev_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = err_word(ST_EMPTY_RANGE);
                        state_next     = S_FAILED;
                    end
                    else
                    begin
                        cell_ctl.fill = 1'b1;
                        cell_ctl.lo   = prev_idx;
                        cell_ctl.hi   = c_idx;
                        prev_next     = 8'd0;
                        state_next    = S_NORMAL;
                    end
                end
            end

            S_FAILED:
            begin
                if (accept && term)
                begin
                    cell_ctl.clear = 1'b1;
                    prev_next      = 8'd0;
                    state_next     = S_NORMAL;
                end
            end

            S_COUNT:
            begin
                // one full rotation leaves the mask back in place
                cell_ctl.shift = 1'b1;
                cnt_next       = cnt_reg + CNT_W'(members[0]);
                rot_next       = rot_reg + CNT_W'(1);
                if (rot_reg == CNT_W'(NUM_CELLS - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_W-MASK_W-COUNT_W-STATUS_W){1'b0}},
                                      mask,
                                      COUNT_W'(cnt_reg),
                                      (32'(cnt_reg) < MIN_MEMBERS) ? ST_TOO_FEW : ST_OK};
                    cell_ctl.clear = 1'b1;
                    state_next     = S_NORMAL;
                end
            end

            default:
            begin
                state_next = S_NORMAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_NORMAL;
            prev_reg      <= 8'd0;
            cnt_reg       <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### rtl/core/ccp_checker.sv
// Port-level checker for the character class parser, bound to the top level.
// Depends on ccp_pkg and character_class_parser.
module ccp_checker
    import ccp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                err;

    assign status = m_axis_tdata[STATUS_W-1:0];
    assign count  = m_axis_tdata[STATUS_W+COUNT_W-1:STATUS_W];
    assign err    = (status != ST_OK) && (status != ST_TOO_FEW);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // an error result carries no count and no mask
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && err |-> (m_axis_tdata[OUT_W-1:STATUS_W] == '0))
        else $error("error result with nonzero payload");

    // too-few status exactly when a terminator result has fewer than two members
    a_few: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !err |-> ((status == ST_TOO_FEW) == (32'(count) < MIN_MEMBERS)))
        else $error("status does not match member count");

    // status is a defined code and the pad bits above the mask stay zero
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status != 3'd7) && (m_axis_tdata[OUT_W-1:STATUS_W+COUNT_W+MASK_W] == '0))
        else $error("bad status code or pad bits");

endmodule

bind character_class_parser ccp_checker u_ccp_checker (.*);

### test/character_class_parser_check.sv
// Result checker for the character class parser: predicts each result from the accepted
// specification bytes and compares it field by field with what the block returns.
// Depends on ccp_pkg; instantiated by character_class_parser_test beside the block.
module character_class_parser_check
    import ccp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,    // [7:0] ch
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,    // [2:0] status, [9:3] member_count,
                                              // [73:10] mask_low, [104:74] mask_high,
                                              // [111:105] zero
    output int               mismatches,
    output int               results_waiting,
    output int               bytes_parsed
);
    timeunit 1ns;
    timeprecision 1ps;

    // Highest field first, so the struct lines up with the low bits of tdata.
    typedef struct packed {
        logic [MASK_HI_W-1:0] mask_high;
        logic [MASK_LO_W-1:0] mask_low;
        logic [COUNT_W-1:0]   count;
        logic [STATUS_W-1:0]  status;
    } class_result_t;

    typedef enum logic [1:0] {
        PS_PLAIN,
        PS_ESCAPED,
        PS_RANGE,
        PS_RANGE_ESCAPED
    } parse_state_t;

    logic [127:0]  member_set;
    parse_state_t  parse_state;
    logic [7:0]    range_start;       // zero: no range start pending
    logic          in_error;

    class_result_t expected_results[$];
    class_result_t predicted;
    int            fail_total;
    int            parsed_total;

    function automatic logic printable_char(input logic [7:0] c);
        return c >= CH_SPACE && c < CH_HIGH && (int'(c) - 32) < ALPHABET_SIZE;
    endfunction

    function automatic void reset_parser();
        member_set  = '0;
        parse_state = PS_PLAIN;
        range_start = '0;
        in_error    = 1'b0;
    endfunction

    function automatic void add_range(input logic [7:0] lo, input logic [7:0] hi);
        for (int k = int'(lo); k <= int'(hi); k++)
            member_set[(k - 32) & 127] = 1'b1;
    endfunction

    // Error result carries only the status; a terminator clears at once, anything else
    // parks the parser until the next terminator.
    function automatic class_result_t error_result(input logic [STATUS_W-1:0] code,
                                                   input bit terminal);
        class_result_t r;
        r = '0;
        r.status = code;
        if (terminal)
            reset_parser();
        else
            in_error = 1'b1;
        return r;
    endfunction

    function automatic bit close_range(input logic [7:0] c, output class_result_t r);
        r = '0;
        if (!printable_char(c))
        begin
            r = error_result(ST_NONPRINT, 1'b0);
            return 1'b1;
        end
        if (c < range_start)
        begin
            r = error_result(ST_EMPTY_RANGE, 1'b0);
            return 1'b1;
        end
        add_range(range_start, c);
        range_start = '0;
        parse_state = PS_PLAIN;
        return 1'b0;
    endfunction

    // Returns 1 when the byte produces a result.
    function automatic bit parse_byte(input logic [7:0] c, output class_result_t r);
        logic term;
        int   members;
        term = (c == CH_NUL) || (c == CH_SPACE);
        r    = '0;
        if (in_error)
        begin
            if (term)
                reset_parser();
            return 1'b0;
        end
        case (parse_state)
            PS_ESCAPED:
            begin
                if (c == CH_NUL)
                begin
                    r = error_result(ST_DANGLING, 1'b1);
                    return 1'b1;
                end
                if (!printable_char(c))
                begin
                    r = error_result(ST_NONPRINT, 1'b0);
                    return 1'b1;
                end
                add_range(c, c);
                range_start = c;
                parse_state = PS_PLAIN;
                return 1'b0;
            end
            PS_RANGE:
            begin
                if (c == CH_BACKSLASH)
                begin
                    parse_state = PS_RANGE_ESCAPED;
                    return 1'b0;
                end
                if (term)
                begin
                    r = error_result(ST_NO_END, 1'b1);
                    return 1'b1;
                end
                return close_range(c, r);
            end
            PS_RANGE_ESCAPED:
            begin
                if (c == CH_NUL)
                begin
                    r = error_result(ST_NO_END, 1'b1);
                    return 1'b1;
                end
                return close_range(c, r);
            end
            default: ;
        endcase
        if (term)
        begin
            members     = $countones(member_set);
            r.status    = (members < MIN_MEMBERS) ? ST_TOO_FEW : ST_OK;
            r.count     = members[COUNT_W-1:0];
            r.mask_low  = member_set[MASK_LO_W-1:0];
            r.mask_high = member_set[MASK_W-1:MASK_LO_W];
            reset_parser();
            return 1'b1;
        end
        if (c == CH_BACKSLASH)
        begin
            parse_state = PS_ESCAPED;
            return 1'b0;
        end
        if (!printable_char(c))
        begin
            r = error_result(ST_NONPRINT, 1'b0);
            return 1'b1;
        end
        if (c == CH_HYPHEN)
        begin
            if (range_start == '0)
            begin
                r = error_result(ST_NO_START, 1'b0);
                return 1'b1;
            end
            parse_state = PS_RANGE;
            return 1'b0;
        end
        add_range(c, c);
        range_start = c;
        return 1'b0;
    endfunction

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("t=%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_total++;
        end
    endtask

    task automatic check_result(input logic [OUT_W-1:0] word);
        class_result_t got;
        class_result_t want;
        got = class_result_t'(word[$bits(class_result_t)-1:0]);
        if (expected_results.size() == 0)
        begin
            $display("t=%0t: unexpected result, expected none, got 0x%0h", $time, word);
            fail_total++;
            return;
        end
        want = expected_results.pop_front();
        report_field("status", 64'(want.status), 64'(got.status));
        report_field("member_count", 64'(want.count), 64'(got.count));
        report_field("mask_low", want.mask_low, got.mask_low);
        report_field("mask_high", 64'(want.mask_high), 64'(got.mask_high));
    endtask

    // Result side first: a result leaving now never belongs to a byte taken now.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            expected_results.delete();
            fail_total      = 0;
            parsed_total    = 0;
            mismatches      <= 0;
            results_waiting <= 0;
            bytes_parsed    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                parsed_total++;
                if (parse_byte(s_axis_tdata, predicted))
                    expected_results.push_back(predicted);
            end
            mismatches      <= fail_total;
            results_waiting <= expected_results.size();
            bytes_parsed    <= parsed_total;
        end
    end

endmodule

### test/character_class_parser_test.sv
// Testbench top for the character class parser: drives specification bytes, paces the
// result channel and gives the verdict. Depends on ccp_pkg, character_class_parser and
// character_class_parser_check (which predicts and compares every result).
module character_class_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    localparam int ITEM_TARGET  = 1950;   // bytes accepted by the block
    localparam int IDLE_PCT     = 29;     // chance per cycle that a side idles
    localparam int HOLD_START   = 600;    // byte count at which the long hold-off begins
    localparam int HOLD_CYCLES  = 400;
    localparam int STEADY_START = 1200;   // stretch with no idling on either side
    localparam int STEADY_END   = 1500;
    localparam int DRAIN_CYCLES = 200;    // margin beyond the count pass
    // Longest legal quiet spell: hold-off plus a count pass plus idling; several times over.
    localparam int QUIET_LIMIT  = 2000;
    localparam int OPENING_LEN  = 26;

    // Opening directed bytes, sent from the leftmost one on.
    localparam logic [8*OPENING_LEN-1:0] OPENING = {
        // escaped space, then a range up to an escaped '~': the whole alphabet, ok
        CH_BACKSLASH, CH_SPACE, CH_HYPHEN, CH_BACKSLASH, "~", CH_NUL,
        // hyphen with nothing before it; the 0xFF after it is ignored, space clears
        CH_HYPHEN, 8'hFF, CH_SPACE,
        // range cut short by a space
        "!", CH_HYPHEN, CH_SPACE,
        // reversed range, NUL clears the failed state
        "z", CH_HYPHEN, "a", CH_NUL,
        // backslash right before NUL
        CH_BACKSLASH, CH_NUL,
        // escaped NUL as a range end
        "a", CH_HYPHEN, CH_BACKSLASH, CH_NUL,
        // escaped DEL is not printable
        CH_BACKSLASH, 8'h7F, CH_SPACE,
        // empty set: too few members
        CH_NUL
    };

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [7:0] ch
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // [2:0] status, [9:3] member_count,
                                            // [73:10] mask_low, [104:74] mask_high,
                                            // [111:105] zero

    int mismatches;
    int results_waiting;
    int bytes_parsed;
    int quiet_cycles = 0;
    bit no_gaps      = 1'b0;   // both sides run flat out while set
    bit hold_req     = 1'b0;   // asks the receiver for its one long hold-off
    bit hold_done    = 1'b0;

    character_class_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    character_class_parser_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .results_waiting (results_waiting),
        .bytes_parsed    (bytes_parsed)
    );

    always #1 clk = ~clk;

    // One byte per transfer. Valid stays up between back-to-back bytes; a random gap
    // drops it first. Returns at the edge where the byte was taken.
    task automatic send_byte(input logic [7:0] c);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // A printable character as a member or range end. Space, backslash and (outside a
    // range end) hyphen must be escaped; others get escaped now and then anyway.
    task automatic send_char(input logic [7:0] c, input bit hyphen_plain);
        if (c == CH_SPACE || c == CH_BACKSLASH || (c == CH_HYPHEN && !hyphen_plain)
            || $urandom_range(7) == 0)
            send_byte(CH_BACKSLASH);
        send_byte(c);
    endtask

    // Mostly legal specification: members and ranges, then a terminator. The odd
    // reversed range is thrown in.
    task automatic send_wellformed();
        int         tokens;
        logic [7:0] lo;
        logic [7:0] hi;
        tokens = $urandom_range(5);
        repeat (tokens)
        begin
            lo = 8'($urandom_range(32, 126));
            send_char(lo, 1'b0);
            if ($urandom_range(2) == 0)
            begin
                if (lo > CH_SPACE && $urandom_range(19) == 0)
                    hi = 8'($urandom_range(32, int'(lo) - 1));
                else
                    hi = 8'($urandom_range(int'(lo), 126));
                send_byte(CH_HYPHEN);
                send_char(hi, 1'b1);
            end
        end
        send_byte($urandom_range(1) ? CH_SPACE : CH_NUL);
    endtask

    // Junk weighted toward the bytes the parser treats specially.
    task automatic send_noise();
        int         len;
        logic [7:0] c;
        len = $urandom_range(1, 8);
        repeat (len)
        begin
            case ($urandom_range(9))
                0: c = CH_BACKSLASH;
                1: c = CH_HYPHEN;
                2: c = CH_NUL;
                3: c = CH_SPACE;
                4: c = 8'($urandom_range(127, 255));
                5: c = 8'($urandom_range(1, 31));
                default: c = 8'($urandom);
            endcase
            send_byte(c);
        end
        send_byte($urandom_range(1) ? CH_SPACE : CH_NUL);
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = OPENING_LEN - 1; i >= 0; i--)
            send_byte(OPENING[i*8 +: 8]);
        while (bytes_parsed < ITEM_TARGET)
        begin
            hold_req = (bytes_parsed >= HOLD_START);
            no_gaps  = (bytes_parsed >= STEADY_START && bytes_parsed < STEADY_END);
            if ($urandom_range(99) < 75)
                send_wellformed();
            else
                send_noise();
        end
        s_axis_tvalid <= 1'b0;
        // let the checker update results_waiting so the last byte's expectation is counted
        @(posedge clk);
        wait (results_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side. The single long hold-off is counted here while the sender keeps
    // offering bytes, so the result register fills and the block stalls its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

### character_class_parser.f
rtl/core/ccp_pkg.sv
rtl/core/ccp_cell.sv
rtl/core/ccp_chain.sv
rtl/core/character_class_parser.sv
rtl/core/ccp_checker.sv
test/character_class_parser_check.sv
test/character_class_parser_test.sv
